@@ rtl/core/tap_pkg.sv @@
package tap_pkg;

   // Data path width, Q8.24 fixed point
   localparam int DW      = 32;
   localparam int FRAC    = 24;
   localparam int SUM_W   = DW + 3;
   localparam int DIG     = 4;
   localparam int STEPS   = DW / DIG;
   localparam int CNT_W   = $clog2(STEPS);
   localparam int LIMIT_W = DW - 1;
   localparam int ADDR_W  = 3;

   localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

   // 0.7 and 0.3 in Q8.24
   localparam logic signed [DW-1:0] COEF_NEW = DW'(11744051);
   localparam logic signed [DW-1:0] COEF_OLD = DW'(5033165);
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET = LIMIT_W'(167772);

   localparam logic [ADDR_W-1:0] CSR_GAIN_PROP  = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] CSR_GAIN_INTEG = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] CSR_GAIN_DERIV = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] CSR_PITCH_LIM  = ADDR_W'(3);
   localparam logic [ADDR_W-1:0] CSR_YAW_LIM    = ADDR_W'(4);

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_RUN,
      TOP_HOLD
   } top_state_type;

   typedef enum logic [2:0] {
      AX_IDLE,
      AX_ERR,
      AX_DIFF,
      AX_MUL_GO,
      AX_MUL_WAIT,
      AX_CLAMP,
      AX_WIND
   } ax_state_type;

   typedef enum logic [2:0] {
      MOP_ERR_NEW,
      MOP_INT_OLD,
      MOP_ERR_KP,
      MOP_DIFF_KD,
      MOP_INT_KI
   } mop_type;

   typedef struct packed {
      logic                 start;
      logic signed [DW-1:0] cur;
      logic signed [DW-1:0] tgt;
      logic signed [DW-1:0] rate;
   } ax_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic signed [DW-1:0] torque;
   } ax_sts_type;

   typedef struct packed {
      logic signed [DW-1:0] kp;
      logic signed [DW-1:0] ki;
      logic signed [DW-1:0] kd;
   } gain_type;

   function automatic logic signed [SUM_W-1:0] tap_ext(input logic signed [DW-1:0] v);
      return SUM_W'(v);
   endfunction

   function automatic logic signed [DW-1:0] tap_sat(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(DMAX);
      lo = SUM_W'(DMIN);
      if (x > hi) begin
         return DMAX;
      end else if (x < lo) begin
         return DMIN;
      end
      return x[DW-1:0];
   endfunction

endpackage

@@ rtl/core/tap_if.sv @@
interface tap_req_if import tap_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] current_pitch;
   logic signed [DW-1:0] current_yaw;
   logic signed [DW-1:0] target_pitch;
   logic signed [DW-1:0] target_yaw;
   logic signed [DW-1:0] pitch_rate;
   logic signed [DW-1:0] yaw_rate;

   modport source (
      output valid, current_pitch, current_yaw, target_pitch, target_yaw,
             pitch_rate, yaw_rate,
      input  ready
   );
   modport sink (
      input  valid, current_pitch, current_yaw, target_pitch, target_yaw,
             pitch_rate, yaw_rate,
      output ready
   );
endinterface

interface tap_rsp_if import tap_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] pitch_torque;
   logic signed [DW-1:0] yaw_torque;

   modport source (output valid, pitch_torque, yaw_torque, input ready);
   modport sink (input valid, pitch_torque, yaw_torque, output ready);
endinterface

interface tap_csr_if import tap_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] addr;
   logic [DW-1:0]     data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

@@ rtl/core/tap_mul.sv @@
module tap_mul import tap_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] a,
   input  logic signed [DW-1:0] b,
   output logic                 done,
   output logic signed [DW-1:0] p
);

   localparam int QW = 2 * DW - FRAC;
   localparam logic [QW-1:0] Q_POS_MAX = {{(QW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic [QW-1:0] Q_NEG_MAX = {{(QW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

   logic                  run_ff, run_in;
   logic                  fin_ff, fin_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic [DW-1:0]         ua_ff, ua_in;
   logic [DW-1:0]         ub_ff, ub_in;
   logic [2*DW-1:0]       acc_ff, acc_in;
   logic signed [DW-1:0]  p_ff, p_in;

   logic [DIG-1:0]        digit;
   logic [DW+DIG-1:0]     part;
   logic [DW+DIG-1:0]     sum_hi;
   logic [QW-1:0]         q;
   logic [QW-1:0]         mag;
   logic [QW-1:0]         neg_mag;
   logic                  frac_nz;

   assign digit   = ub_ff[DIG-1:0];
   assign part    = (DW+DIG)'(ua_ff) * (DW+DIG)'(digit);
   assign sum_hi  = (DW+DIG)'(acc_ff[2*DW-1:DW]) + part;
   assign q       = acc_ff[2*DW-1:FRAC];
   assign frac_nz = |acc_ff[FRAC-1:0];
   // floor for negative products: round the magnitude up when bits fall off
   assign mag     = q + {{(QW-1){1'b0}}, neg_ff & frac_nz};
   assign neg_mag = ~mag + 1'b1;

   always_comb begin
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      acc_in  = acc_ff;
      p_in    = p_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         neg_in = a[DW-1] ^ b[DW-1];
         ua_in  = a[DW-1] ? (~a + 1'b1) : a;
         ub_in  = b[DW-1] ? (~b + 1'b1) : b;
         acc_in = '0;
      end else if (run_ff) begin
         // one digit of b per cycle, accumulator shifts right
         acc_in = {sum_hi, acc_ff[DW-1:DIG]};
         ub_in  = ub_ff >> DIG;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      if (fin_ff) begin
         if (!neg_ff) begin
            p_in = (mag > Q_POS_MAX) ? DMAX : mag[DW-1:0];
         end else begin
            p_in = (mag > Q_NEG_MAX) ? DMIN : neg_mag[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      acc_ff <= acc_in;
      p_ff   <= p_in;
   end

   assign done = done_ff;
   assign p    = p_ff;

endmodule

@@ rtl/core/tap_axis.sv @@
module tap_axis import tap_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ax_cmd_type         cmd,
   input  gain_type           gain,
   input  logic [LIMIT_W-1:0] limit,
   output ax_sts_type         sts
);

   ax_state_type          state_ff, state_in;
   mop_type               mop_ff, mop_in;
   logic signed [DW-1:0]  cur_ff, cur_in;
   logic signed [DW-1:0]  tgt_ff, tgt_in;
   logic signed [DW-1:0]  rate_ff, rate_in;
   logic signed [DW-1:0]  err_ff, err_in;
   logic signed [DW-1:0]  diff_ff, diff_in;
   logic signed [DW-1:0]  last_err_ff, last_err_in;
   logic signed [DW-1:0]  integ_ff, integ_in;
   logic signed [DW-1:0]  raw_ff, raw_in;
   logic signed [DW-1:0]  out_ff, out_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic                  mul_start;
   logic signed [DW-1:0]  mul_a;
   logic signed [DW-1:0]  mul_b;
   logic                  mul_done;
   logic signed [DW-1:0]  mul_p;

   logic signed [DW:0]    lim_ext;
   logic signed [DW:0]    neg_lim;
   logic signed [DW:0]    out_ext;

   assign lim_ext = signed'({{(DW+1-LIMIT_W){1'b0}}, limit});
   assign neg_lim = -lim_ext;
   assign out_ext = {out_ff[DW-1], out_ff};

   tap_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   always_comb begin
      case (mop_ff)
         MOP_ERR_NEW: begin
            mul_a = err_ff;
            mul_b = COEF_NEW;
         end
         MOP_INT_OLD: begin
            mul_a = integ_ff;
            mul_b = COEF_OLD;
         end
         MOP_ERR_KP: begin
            mul_a = err_ff;
            mul_b = gain.kp;
         end
         MOP_DIFF_KD: begin
            mul_a = diff_ff;
            mul_b = gain.kd;
         end
         MOP_INT_KI: begin
            mul_a = integ_ff;
            mul_b = gain.ki;
         end
         default: begin
            mul_a = err_ff;
            mul_b = COEF_NEW;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      mop_in      = mop_ff;
      cur_in      = cur_ff;
      tgt_in      = tgt_ff;
      rate_in     = rate_ff;
      err_in      = err_ff;
      diff_in     = diff_ff;
      last_err_in = last_err_ff;
      integ_in    = integ_ff;
      raw_in      = raw_ff;
      out_in      = out_ff;
      sum_in      = sum_ff;
      mul_start   = 1'b0;
      case (state_ff)
         AX_IDLE: begin
            if (cmd.start) begin
               cur_in   = cmd.cur;
               tgt_in   = cmd.tgt;
               rate_in  = cmd.rate;
               state_in = AX_ERR;
            end
         end
         AX_ERR: begin
            err_in   = tap_sat(tap_ext(tgt_ff) - tap_ext(cur_ff));
            state_in = AX_DIFF;
         end
         AX_DIFF: begin
            diff_in  = tap_sat(tap_ext(err_ff) - tap_ext(last_err_ff));
            mop_in   = MOP_ERR_NEW;
            state_in = AX_MUL_GO;
         end
         AX_MUL_GO: begin
            mul_start = 1'b1;
            state_in  = AX_MUL_WAIT;
         end
         AX_MUL_WAIT: begin
            if (mul_done) begin
               state_in = AX_MUL_GO;
               case (mop_ff)
                  MOP_ERR_NEW: begin
                     sum_in = tap_ext(mul_p);
                     mop_in = MOP_INT_OLD;
                  end
                  MOP_INT_OLD: begin
                     integ_in = tap_sat(sum_ff + tap_ext(mul_p));
                     mop_in   = MOP_ERR_KP;
                  end
                  MOP_ERR_KP: begin
                     sum_in = tap_ext(mul_p) - tap_ext(rate_ff);
                     mop_in = MOP_DIFF_KD;
                  end
                  MOP_DIFF_KD: begin
                     raw_in = tap_sat(sum_ff + tap_ext(mul_p));
                     mop_in = MOP_INT_KI;
                  end
                  MOP_INT_KI: begin
                     out_in   = tap_sat(tap_ext(raw_ff) + tap_ext(mul_p));
                     state_in = AX_CLAMP;
                  end
                  default: begin
                     state_in = AX_IDLE;
                  end
               endcase
            end
         end
         AX_CLAMP: begin
            if (out_ext > lim_ext) begin
               out_in = lim_ext[DW-1:0];
            end else if (out_ext < neg_lim) begin
               out_in = neg_lim[DW-1:0];
            end
            state_in = AX_WIND;
         end
         AX_WIND: begin
            // anti-windup: keep only what the clamp let through
            integ_in    = tap_sat(tap_ext(out_ff) - tap_ext(raw_ff));
            last_err_in = err_ff;
            state_in    = AX_IDLE;
         end
         default: begin
            state_in = AX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= AX_IDLE;
         mop_ff      <= MOP_ERR_NEW;
         last_err_ff <= '0;
         integ_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         mop_ff      <= mop_in;
         last_err_ff <= last_err_in;
         integ_ff    <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      tgt_ff  <= tgt_in;
      rate_ff <= rate_in;
      err_ff  <= err_in;
      diff_ff <= diff_in;
      raw_ff  <= raw_in;
      out_ff  <= out_in;
      sum_ff  <= sum_in;
   end

   assign sts.busy   = (state_ff != AX_IDLE);
   assign sts.torque = out_ff;

endmodule

@@ rtl/core/two_axis_attitude_pid_core.sv @@
// Two-axis (pitch, yaw) attitude PID with anti-windup, signed Q8.24 throughout.
// One sample is taken at a time; the next request is taken in the cycle after
// the response is loaded. Each axis computes five products in turn on its own
// 4-bit digit-serial multiplier, after the error and the error step and before
// the clamp and anti-windup, and then the response is loaded; both axes run side
// by side. The response sits in an output register, so a new request is accepted
// while the previous response waits to be taken.
// Gains and limits are to be written through the csr port only while no sample
// is in flight, and the block leaves this to the user; the csr port is always
// ready. Integrator and last-error state clear on reset.
module two_axis_attitude_pid_core import tap_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tap_req_if.sink   req_ch,
   tap_rsp_if.source rsp_ch,
   tap_csr_if.sink   csr_ch
);

   top_state_type        state_ff, state_in;
   gain_type             gain_ff;
   logic [LIMIT_W-1:0]   lim_p_ff;
   logic [LIMIT_W-1:0]   lim_y_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] pt_ff, pt_in;
   logic signed [DW-1:0] yt_ff, yt_in;

   logic                 accept;
   logic                 load;
   logic                 slot_free;
   ax_cmd_type           cmd_p;
   ax_cmd_type           cmd_y;
   ax_sts_type           sts_p;
   ax_sts_type           sts_y;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign cmd_p.start = accept;
   assign cmd_p.cur   = req_ch.current_pitch;
   assign cmd_p.tgt   = req_ch.target_pitch;
   assign cmd_p.rate  = req_ch.pitch_rate;
   assign cmd_y.start = accept;
   assign cmd_y.cur   = req_ch.current_yaw;
   assign cmd_y.tgt   = req_ch.target_yaw;
   assign cmd_y.rate  = req_ch.yaw_rate;

   tap_axis u_pitch (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_p),
      .gain  (gain_ff),
      .limit (lim_p_ff),
      .sts   (sts_p)
   );

   tap_axis u_yaw (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_y),
      .gain  (gain_ff),
      .limit (lim_y_ff),
      .sts   (sts_y)
   );

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      load         = 1'b0;
      case (state_ff)
         TOP_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = TOP_RUN;
            end
         end
         TOP_RUN: begin
            if (!sts_p.busy && !sts_y.busy) begin
               if (slot_free) begin
                  load     = 1'b1;
                  state_in = TOP_IDLE;
               end else begin
                  state_in = TOP_HOLD;
               end
            end
         end
         TOP_HOLD: begin
            if (slot_free) begin
               load     = 1'b1;
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   always_comb begin
      pt_in        = pt_ff;
      yt_in        = yt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (load) begin
         pt_in        = sts_p.torque;
         yt_in        = sts_y.torque;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
      yt_ff <= yt_in;
   end

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= '0;
         lim_p_ff <= LIMIT_RESET;
         lim_y_ff <= LIMIT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            CSR_GAIN_PROP:  gain_ff.kp <= csr_ch.data;
            CSR_GAIN_INTEG: gain_ff.ki <= csr_ch.data;
            CSR_GAIN_DERIV: gain_ff.kd <= csr_ch.data;
            CSR_PITCH_LIM:  lim_p_ff   <= csr_ch.data[LIMIT_W-1:0];
            CSR_YAW_LIM:    lim_y_ff   <= csr_ch.data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pitch_torque = pt_ff;
   assign rsp_ch.yaw_torque   = yt_ff;

endmodule

@@ rtl/core/tap_chk.sv @@
module tap_chk import tap_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [DW-1:0] rsp_pitch,
   input logic [DW-1:0] rsp_yaw
);

   // a stalled response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pitch) && $stable(rsp_yaw))
      else $error("response payload changed while stalled");

   // one sample in flight: ready drops after each request beat
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a sample is in flight");

   // a new response only comes out of a sample in flight
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised with no sample in flight");

endmodule

bind two_axis_attitude_pid_core tap_chk u_tap_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_pitch (rsp_ch.pitch_torque),
   .rsp_yaw   (rsp_ch.yaw_torque)
);

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tap_pkg::*;

   localparam int LIMIT_CYCLES   = 2_000_000;
   localparam int HOLD_CYCLES    = 600;
   localparam int DRAIN_CYCLES   = 80;
   localparam int RAND_PER_PHASE = 153;
   localparam int PITCH          = 0;
   localparam int YAW            = 1;
   localparam int Q_ONE          = 1 << FRAC;

   typedef struct packed {
      logic signed [DW-1:0] current_pitch;
      logic signed [DW-1:0] current_yaw;
      logic signed [DW-1:0] target_pitch;
      logic signed [DW-1:0] target_yaw;
      logic signed [DW-1:0] pitch_rate;
      logic signed [DW-1:0] yaw_rate;
   } attitude_sample_type;

   typedef struct packed {
      logic signed [DW-1:0] pitch_torque;
      logic signed [DW-1:0] yaw_torque;
   } torque_type;

   logic clock;
   logic reset;

   tap_req_if req_if();
   tap_rsp_if rsp_if();
   tap_csr_if csr_if();

   two_axis_attitude_pid_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // controller shadow: gains, clamps and per-axis loop state
   longint  kp_gain = 0;
   longint  ki_gain = 0;
   longint  kd_gain = 0;
   longint  torque_lim [2] = '{longint'(LIMIT_RESET), longint'(LIMIT_RESET)};
   longint  prev_err [2] = '{0, 0};
   longint  integ_acc [2] = '{0, 0};

   torque_type  torque_due [$];
   int          err_count = 0;
   bit          calm = 0;
   bit          rsp_hold_req = 0;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clip_dw(longint x);
      if (x > longint'(DMAX)) begin
         return longint'(DMAX);
      end
      if (x < longint'(DMIN)) begin
         return longint'(DMIN);
      end
      return x;
   endfunction

   // Q8.24 product, floor toward minus infinity, then saturate
   function automatic longint q_mul(longint a, longint b);
      return clip_dw((a * b) >>> FRAC);
   endfunction

   function automatic logic signed [DW-1:0] axis_torque(int ax, longint cur, longint tgt,
                                                        longint rate);
      longint err;
      longint diff;
      longint raw;
      longint out;
      longint lim;
      err = clip_dw(tgt - cur);
      diff = clip_dw(err - prev_err[ax]);
      integ_acc[ax] = clip_dw(q_mul(err, longint'(COEF_NEW)) +
                              q_mul(integ_acc[ax], longint'(COEF_OLD)));
      raw = clip_dw(q_mul(err, kp_gain) - rate + q_mul(diff, kd_gain));
      out = clip_dw(raw + q_mul(integ_acc[ax], ki_gain));
      lim = torque_lim[ax];
      if (lim > longint'(DMAX)) begin
         lim = longint'(DMAX);
      end
      if (out > lim) begin
         out = lim;
      end else if (out < -lim) begin
         out = -lim;
      end
      // anti-windup: integrator keeps only what the clamp let through
      integ_acc[ax] = clip_dw(out - raw);
      prev_err[ax] = err;
      return out[DW-1:0];
   endfunction

   function automatic torque_type predict_torque(attitude_sample_type s);
      torque_type t;
      t.pitch_torque = axis_torque(PITCH, $signed(s.current_pitch), $signed(s.target_pitch),
                                   $signed(s.pitch_rate));
      t.yaw_torque = axis_torque(YAW, $signed(s.current_yaw), $signed(s.target_yaw),
                                 $signed(s.yaw_rate));
      return t;
   endfunction

   function automatic void apply_csr(logic [ADDR_W-1:0] a, logic [DW-1:0] d);
      case (a)
         CSR_GAIN_PROP:  kp_gain = longint'($signed(d));
         CSR_GAIN_INTEG: ki_gain = longint'($signed(d));
         CSR_GAIN_DERIV: kd_gain = longint'($signed(d));
         CSR_PITCH_LIM:  torque_lim[PITCH] = longint'(d[LIMIT_W-1:0]);
         CSR_YAW_LIM:    torque_lim[YAW] = longint'(d[LIMIT_W-1:0]);
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 80);
   endfunction

   function automatic logic signed [DW-1:0] corner_value();
      case ($urandom_range(0, 4))
         0: return DMAX;
         1: return DMIN;
         2: return '0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   function automatic logic signed [DW-1:0] near_zero(int span);
      return DW'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic [DW-1:0] rand_gain();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return corner_value();
         default: return near_zero(1 << 26);
      endcase
   endfunction

   function automatic logic [DW-1:0] rand_limit();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return $urandom | 32'h7FFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 1 << 25);
      endcase
   endfunction

   function automatic attitude_sample_type mk_sample(logic signed [DW-1:0] cp, cy, tp, ty,
                                                     rp, ry);
      attitude_sample_type s;
      s.current_pitch = cp;
      s.current_yaw = cy;
      s.target_pitch = tp;
      s.target_yaw = ty;
      s.pitch_rate = rp;
      s.yaw_rate = ry;
      return s;
   endfunction

   function automatic attitude_sample_type rand_sample();
      attitude_sample_type s;
      case ($urandom_range(0, 9))
         0: begin
            s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         end
         1: begin
            s = mk_sample(corner_value(), corner_value(), corner_value(), corner_value(),
                          corner_value(), corner_value());
         end
         default: begin
            // ordinary flight: angles within a few radians, target close to current
            s.current_pitch = near_zero(1 << 25);
            s.current_yaw = near_zero(1 << 25);
            s.target_pitch = s.current_pitch + near_zero(1 << 22);
            s.target_yaw = s.current_yaw + near_zero(1 << 22);
            s.pitch_rate = near_zero(1 << 22);
            s.yaw_rate = near_zero(1 << 22);
         end
      endcase
      return s;
   endfunction

   function automatic void check_torque(logic signed [DW-1:0] p, logic signed [DW-1:0] y);
      torque_type want;
      if (torque_due.size() == 0) begin
         $error("response beat with no pending sample: pitch %0d yaw %0d", p, y);
         err_count++;
         return;
      end
      want = torque_due.pop_front();
      if (p !== want.pitch_torque) begin
         $error("pitch_torque: expected %0d, actual %0d", want.pitch_torque, p);
         err_count++;
      end
      if (y !== want.yaw_torque) begin
         $error("yaw_torque: expected %0d, actual %0d", want.yaw_torque, y);
         err_count++;
      end
   endfunction

   task automatic write_csr(logic [ADDR_W-1:0] a, logic [DW-1:0] d);
      csr_if.valid <= 1'b1;
      csr_if.addr <= a;
      csr_if.data <= d;
      do @(posedge clock); while (!csr_if.ready);
      apply_csr(a, d);
   endtask

   task automatic program_pid(logic [DW-1:0] kp, ki, kd, lim_p, lim_y);
      write_csr(CSR_GAIN_PROP, kp);
      write_csr(CSR_GAIN_INTEG, ki);
      write_csr(CSR_GAIN_DERIV, kd);
      write_csr(CSR_PITCH_LIM, lim_p);
      write_csr(CSR_YAW_LIM, lim_y);
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_sample(attitude_sample_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.current_pitch <= s.current_pitch;
      req_if.current_yaw <= s.current_yaw;
      req_if.target_pitch <= s.target_pitch;
      req_if.target_yaw <= s.target_yaw;
      req_if.pitch_rate <= s.pitch_rate;
      req_if.yaw_rate <= s.yaw_rate;
      do @(posedge clock); while (!req_if.ready);
      torque_due.push_back(predict_torque(s));
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (torque_due.size() != 0);
   endtask

   // gains at zero: torque is just the negated rate, clamped to the reset limit
   task automatic test_reset_config();
      send_sample(mk_sample('0, '0, '0, '0, '0, '0));
      send_sample(mk_sample('0, '0, '0, '0, DMAX, DMIN));
      send_sample(mk_sample(DMIN, DMAX, DMAX, DMIN, DMIN, DMAX));
      send_sample(mk_sample('0, '0, '0, '0, -1000, 1000));
      wait_idle();
   endtask

   task automatic test_register_writes();
      program_pid(Q_ONE, Q_ONE / 2, Q_ONE * 2, 32'h8000_1000, 32'hFFFF_F000);
      send_sample(mk_sample(Q_ONE, -Q_ONE, '0, '0, '0, '0));
      send_sample(mk_sample(Q_ONE, -Q_ONE, Q_ONE / 4, Q_ONE / 4, 100, -100));
      wait_idle();
      // unmapped indexes must not disturb anything
      for (int a = int'(CSR_YAW_LIM) + 1; a < (1 << ADDR_W); a++) begin
         write_csr(ADDR_W'(a), $urandom);
      end
      csr_if.valid <= 1'b0;
      send_sample(mk_sample(-Q_ONE, Q_ONE, '0, Q_ONE, -100, 100));
      wait_idle();
   endtask

   task automatic test_extremes();
      program_pid(Q_ONE, Q_ONE / 2, Q_ONE * 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // error saturates, then the error step saturates on the swing back
      send_sample(mk_sample(DMIN, DMAX, DMAX, DMIN, '0, '0));
      send_sample(mk_sample(DMAX, DMIN, DMIN, DMAX, '0, '0));
      send_sample(mk_sample('0, '0, '0, '0, DMAX, DMIN));
      send_sample(mk_sample('0, '0, '0, '0, DMIN, DMAX));
      send_sample(mk_sample(-1, 1, 1, -1, -1, 1));
      wait_idle();
      // products saturate at full-scale gains
      program_pid(DMAX, DMIN, DMAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(mk_sample(DMIN, DMAX, DMAX, DMIN, DMAX, DMIN));
      send_sample(mk_sample('0, '0, Q_ONE, -Q_ONE, '0, '0));
      send_sample(mk_sample(DMAX, DMIN, DMIN, DMAX, DMIN, DMAX));
      wait_idle();
      // zero clamp forces zero torque
      program_pid(DMIN, DMAX, DMIN, '0, '0);
      send_sample(mk_sample(DMIN, DMAX, DMAX, DMIN, DMAX, DMIN));
      send_sample(mk_sample('0, '0, Q_ONE, Q_ONE, Q_ONE, -Q_ONE));
      wait_idle();
      // negative gains, tight clamp on one axis only
      program_pid(-Q_ONE, -Q_ONE / 4, -Q_ONE / 8, 1, 32'h0100_0000);
      send_sample(mk_sample(Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, 12345, -12345));
      send_sample(mk_sample(Q_ONE, Q_ONE, Q_ONE, Q_ONE, '0, '0));
      wait_idle();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         calm = (ph % 3 == 2);
         case (ph)
            0: program_pid(DMAX, DMAX, DMAX, '1, '1);
            1: program_pid(DMIN, DMIN, DMIN, '0, '0);
            default: program_pid(rand_gain(), rand_gain(), rand_gain(), rand_limit(),
                                 rand_limit());
         endcase
         repeat (RAND_PER_PHASE) send_sample(rand_sample());
      end
      wait_idle();
      calm = 0;
   endtask

   // receiver holds off while the sender keeps pushing, so the core fills and stalls
   task automatic test_output_stall();
      program_pid(Q_ONE / 2, Q_ONE / 8, Q_ONE / 4, 1 << 24, 1 << 23);
      calm = 1;
      rsp_hold_req = 1;
      repeat (8) send_sample(rand_sample());
      calm = 0;
      wait_idle();
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.current_pitch <= '0;
      req_if.current_yaw <= '0;
      req_if.target_pitch <= '0;
      req_if.target_yaw <= '0;
      req_if.pitch_rate <= '0;
      req_if.yaw_rate <= '0;
      csr_if.valid <= 1'b0;
      csr_if.addr <= '0;
      csr_if.data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_register_writes();
      test_extremes();
      test_output_stall();
      test_random_phases();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            check_torque(rsp_if.pitch_torque, rsp_if.yaw_torque);
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_hold_req) begin
            rsp_hold_req = 0;
            stall_left = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_if.ready <= (stall_left == 0);
            if (stall_left > 0) begin
               stall_left--;
            end
         end
      end
   end

   initial begin
      while (cycle_count <= LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: errors");
      $finish;
   end

endmodule

`default_nettype wire
